@@ hw/rtl/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// jse_pkg: shared types and helpers of the JSON string escaper
// Command format passed from the classifier to the character emitter, plus
// character constants and the small functions both sides need.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

    // What the emitter has to produce for one command.
    typedef enum logic [1:0] {
        CMD_CHAR,   // one character, taken from data[6:0]
        CMD_ESC,    // backslash followed by data[6:0]
        CMD_U16     // backslash, 'u' and four lower-case hex digits of data
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
        logic        last;  // final command caused by its input transaction
    } cmd_t;

    // Output slots of one input transaction, in the order they are sent.
    typedef enum logic [2:0] {
        SLOT_OPEN,      // opening quote
        SLOT_FIN_HI,    // finished sequence, first code unit
        SLOT_FIN_LO,    // finished sequence, low surrogate
        SLOT_FL_LEAD,   // broken sequence, lead byte as \u00xx
        SLOT_FL_B1,     // broken sequence, first held continuation byte
        SLOT_FL_B2,     // broken sequence, second held continuation byte
        SLOT_FRESH,     // the new byte on its own
        SLOT_CLOSE      // closing quote
    } slot_t;

    localparam int NUM_SLOTS = 8;

    localparam logic [6:0]  CH_QUOTE  = 7'h22;
    localparam logic [6:0]  CH_BSLASH = 7'h5c;
    localparam logic [6:0]  CH_SLASH  = 7'h2f;
    localparam logic [6:0]  CH_U      = 7'h75;
    localparam logic [6:0]  CH_ZERO   = 7'h30;
    localparam logic [6:0]  CH_LOWER_A = 7'h61;
    localparam logic [15:0] SURR_HI_BASE = 16'hd800;
    localparam logic [15:0] SURR_LO_BASE = 16'hdc00;
    localparam logic [19:0] SUPP_OFFSET  = 20'h10000;

    // Number of continuation bytes a lead byte asks for; zero if not a lead.
    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if ((b & 8'he0) == 8'hc0) begin
            n = 2'd1;
        end else if ((b & 8'hf0) == 8'he0) begin
            n = 2'd2;
        end else if ((b & 8'hf8) == 8'hf0) begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Command for a byte that is not held as the start of a sequence.
    function automatic cmd_t single_cmd(input logic [7:0] b);
        cmd_t c;
        c.last = 1'b0;
        c.data = {8'h00, b};
        case (b)
            8'h22: begin c.kind = CMD_ESC; c.data = {9'd0, CH_QUOTE};   end
            8'h5c: begin c.kind = CMD_ESC; c.data = {9'd0, CH_BSLASH};  end
            8'h2f: begin c.kind = CMD_ESC; c.data = {9'd0, CH_SLASH};   end
            8'h0a: begin c.kind = CMD_ESC; c.data = {9'd0, 7'h6e};      end
            8'h0d: begin c.kind = CMD_ESC; c.data = {9'd0, 7'h72};      end
            8'h0c: begin c.kind = CMD_ESC; c.data = {9'd0, 7'h66};      end
            8'h08: begin c.kind = CMD_ESC; c.data = {9'd0, 7'h62};      end
            8'h09: begin c.kind = CMD_ESC; c.data = {9'd0, 7'h74};      end
            default:
            begin
                if (b <= 8'h1f || b >= 8'h7f) begin
                    c.kind = CMD_U16;
                end else begin
                    c.kind = CMD_CHAR;
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {3'd0, n};
        end else begin
            c = CH_LOWER_A + {3'd0, n} - 7'd10;
        end
        return c;
    endfunction

    // Index of the final character of a command.
    function automatic logic [2:0] final_step(input cmd_kind_t k);
        logic [2:0] s;
        case (k)
            CMD_CHAR: s = 3'd0;
            CMD_ESC:  s = 3'd1;
            CMD_U16:  s = 3'd5;
            default:  s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jse_in_if.sv @@
// ----------------------------------------------------------------------------
// jse_in_if: raw byte channel
// Valid/ready channel carrying one string byte or an end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jse_out_if.sv @@
// ----------------------------------------------------------------------------
// jse_out_if: escaped character channel
// Valid/ready channel carrying one ASCII character of the quoted output.
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jse_fifo.sv @@
// ----------------------------------------------------------------------------
// jse_fifo: command queue
// Small register queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_fifo #(
    parameter int DEPTH = 4     // at least 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire jse_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output jse_pkg::cmd_t      pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

    jse_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/jse_classify.sv @@
// ----------------------------------------------------------------------------
// jse_classify: byte classifier and UTF-8 tracker
// Accepts bytes and end marks, tracks held UTF-8 sequences and issues each
// transaction's commands into the queue, one per cycle while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_classify (
    input  wire logic     clk,
    input  wire logic     rst_n,
    jse_in_if.sink        raw,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output jse_pkg::cmd_t cmd
);

    localparam int NS = jse_pkg::NUM_SLOTS;

    logic          started_reg, started_next;
    logic [7:0]    pend0_reg, pend0_next;
    logic [7:0]    pend1_reg, pend1_next;
    logic [7:0]    pend2_reg, pend2_next;
    logic [1:0]    pcount_reg, pcount_next;
    logic [1:0]    need_reg, need_next;
    logic [NS-1:0] mask_reg, mask_next;

    // Snapshot of what the issued commands of the current transaction need.
    logic [7:0]    snap_lead_reg, snap_p1_reg, snap_p2_reg, snap_b_reg;
    logic [15:0]   fin_hi_reg, fin_lo_reg;
    logic [15:0]   fin_hi, fin_lo;

    logic          accept;
    logic          is_cont, cont_case, finish, broken, four_byte;
    logic [1:0]    b_need;
    logic [4:0]    lead_m;
    logic [22:0]   cp;
    logic [19:0]   supp;
    logic [NS-1:0] low_onehot, new_mask;
    jse_pkg::slot_t slot;
    jse_pkg::cmd_t  slot_cmd;

    assign raw.ready = (mask_reg == '0);
    assign accept    = raw.valid && raw.ready;

    // Classification of the offered transaction against the held sequence.
    always_comb
    begin
        is_cont   = (raw.in_byte[7:6] == 2'b10);
        b_need    = jse_pkg::lead_need(raw.in_byte);
        cont_case = !raw.mode && (pcount_reg != 2'd0) && is_cont;
        finish    = cont_case && (need_reg <= 2'd1 || pcount_reg == 2'd3);
        broken    = (pcount_reg != 2'd0) && (raw.mode || !is_cont);
        four_byte = ((pend0_reg & 8'hf8) == 8'hf0);

        new_mask = '0;
        new_mask[jse_pkg::SLOT_OPEN]    = !started_reg;
        new_mask[jse_pkg::SLOT_FIN_HI]  = finish;
        new_mask[jse_pkg::SLOT_FIN_LO]  = finish && four_byte;
        new_mask[jse_pkg::SLOT_FL_LEAD] = broken;
        new_mask[jse_pkg::SLOT_FL_B1]   = broken && (pcount_reg >= 2'd2);
        new_mask[jse_pkg::SLOT_FL_B2]   = broken && (pcount_reg == 2'd3);
        new_mask[jse_pkg::SLOT_FRESH]   = !raw.mode && !cont_case && (b_need == 2'd0);
        new_mask[jse_pkg::SLOT_CLOSE]   = raw.mode;
    end

    // Code point of a finished sequence and its UTF-16 code units.
    always_comb
    begin
        if ((pend0_reg & 8'he0) == 8'hc0)
        begin
            lead_m = pend0_reg[4:0];
        end
        else if ((pend0_reg & 8'hf0) == 8'he0)
        begin
            lead_m = {1'b0, pend0_reg[3:0]};
        end
        else
        begin
            lead_m = {2'b00, pend0_reg[2:0]};
        end

        case (pcount_reg)
            2'd1:    cp = {12'd0, lead_m, raw.in_byte[5:0]};
            2'd2:    cp = {6'd0, lead_m, pend1_reg[5:0], raw.in_byte[5:0]};
            default: cp = {lead_m, pend1_reg[5:0], pend2_reg[5:0], raw.in_byte[5:0]};
        endcase

        supp = cp[19:0] - jse_pkg::SUPP_OFFSET;
        if (four_byte)
        begin
            fin_hi = jse_pkg::SURR_HI_BASE + {6'd0, supp[19:10]};
            fin_lo = jse_pkg::SURR_LO_BASE + {6'd0, supp[9:0]};
        end
        else
        begin
            fin_hi = cp[15:0];
            fin_lo = cp[15:0];
        end
    end

    // Sequence state after the offered transaction.
    always_comb
    begin
        started_next = started_reg;
        pend0_next   = pend0_reg;
        pend1_next   = pend1_reg;
        pend2_next   = pend2_reg;
        pcount_next  = pcount_reg;
        need_next    = need_reg;
        mask_next    = mask_reg & ~low_onehot;
        if (!cmd_ready || mask_reg == '0)
        begin
            mask_next = mask_reg;
        end
        if (accept)
        begin
            mask_next    = new_mask;
            started_next = !raw.mode;
            if (raw.mode || finish)
            begin
                pcount_next = 2'd0;
                need_next   = 2'd0;
            end
            else if (cont_case)
            begin
                case (pcount_reg)
                    2'd1:    pend1_next = raw.in_byte;
                    2'd2:    pend2_next = raw.in_byte;
                    default: pend2_next = pend2_reg;
                endcase
                pcount_next = pcount_reg + 2'd1;
                need_next   = need_reg - 2'd1;
            end
            else if (b_need != 2'd0)
            begin
                pend0_next  = raw.in_byte;
                pcount_next = 2'd1;
                need_next   = b_need;
            end
            else
            begin
                pcount_next = 2'd0;
                need_next   = 2'd0;
            end
        end
    end

    // Lowest pending slot goes out next.
    always_comb
    begin
        low_onehot = mask_reg & (~mask_reg + 1'b1);
        slot       = jse_pkg::SLOT_OPEN;
        for (int i = 0; i < NS; i++)
        begin
            if (low_onehot[i])
            begin
                slot = jse_pkg::slot_t'(i);
            end
        end
    end

    always_comb
    begin
        slot_cmd      = '0;
        slot_cmd.kind = jse_pkg::CMD_CHAR;
        case (slot)
            jse_pkg::SLOT_OPEN:
            begin
                slot_cmd.data = {9'd0, jse_pkg::CH_QUOTE};
            end
            jse_pkg::SLOT_FIN_HI:
            begin
                slot_cmd.kind = jse_pkg::CMD_U16;
                slot_cmd.data = fin_hi_reg;
            end
            jse_pkg::SLOT_FIN_LO:
            begin
                slot_cmd.kind = jse_pkg::CMD_U16;
                slot_cmd.data = fin_lo_reg;
            end
            jse_pkg::SLOT_FL_LEAD:
            begin
                slot_cmd.kind = jse_pkg::CMD_U16;
                slot_cmd.data = {8'h00, snap_lead_reg};
            end
            jse_pkg::SLOT_FL_B1:  slot_cmd = jse_pkg::single_cmd(snap_p1_reg);
            jse_pkg::SLOT_FL_B2:  slot_cmd = jse_pkg::single_cmd(snap_p2_reg);
            jse_pkg::SLOT_FRESH:  slot_cmd = jse_pkg::single_cmd(snap_b_reg);
            jse_pkg::SLOT_CLOSE:
            begin
                slot_cmd.data = {9'd0, jse_pkg::CH_QUOTE};
            end
            default:
            begin
                slot_cmd.data = {9'd0, jse_pkg::CH_QUOTE};
            end
        endcase
        slot_cmd.last = ((mask_reg & ~low_onehot) == '0);
    end

    assign cmd_valid = (mask_reg != '0);
    assign cmd       = slot_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pcount_reg  <= 2'd0;
            need_reg    <= 2'd0;
            mask_reg    <= '0;
        end
        else
        begin
            started_reg <= started_next;
            pcount_reg  <= pcount_next;
            need_reg    <= need_next;
            mask_reg    <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
        pend2_reg <= pend2_next;
        if (accept)
        begin
            snap_lead_reg <= pend0_reg;
            snap_p1_reg   <= pend1_reg;
            snap_p2_reg   <= pend2_reg;
            snap_b_reg    <= raw.in_byte;
            fin_hi_reg    <= fin_hi;
            fin_lo_reg    <= fin_lo;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/jse_emit.sv @@
// ----------------------------------------------------------------------------
// jse_emit: character emitter
// Expands queued escape commands into characters through a registered output
// stage, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire jse_pkg::cmd_t cmd,
    jse_out_if.source          escaped
);

    jse_pkg::cmd_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [2:0]    step_reg, step_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    out_char_reg;
    logic          out_last_reg;

    logic          load, at_final, done, pop;
    logic [6:0]    char_now;

    assign load      = cur_valid_reg && (!out_valid_reg || escaped.ready);
    assign at_final  = (step_reg == jse_pkg::final_step(cur_reg.kind));
    assign done      = load && at_final;
    assign cmd_ready = !cur_valid_reg || done;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        case (cur_reg.kind)
            jse_pkg::CMD_CHAR: char_now = cur_reg.data[6:0];
            jse_pkg::CMD_ESC:
            begin
                char_now = (step_reg == 3'd0) ? jse_pkg::CH_BSLASH : cur_reg.data[6:0];
            end
            jse_pkg::CMD_U16:
            begin
                case (step_reg)
                    3'd0:    char_now = jse_pkg::CH_BSLASH;
                    3'd1:    char_now = jse_pkg::CH_U;
                    3'd2:    char_now = jse_pkg::hex_char(cur_reg.data[15:12]);
                    3'd3:    char_now = jse_pkg::hex_char(cur_reg.data[11:8]);
                    3'd4:    char_now = jse_pkg::hex_char(cur_reg.data[7:4]);
                    default: char_now = jse_pkg::hex_char(cur_reg.data[3:0]);
                endcase
            end
            default: char_now = cur_reg.data[6:0];
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            step_next      = 3'd0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load)
        begin
            step_next = step_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (escaped.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= cmd;
        end
        if (load)
        begin
            out_char_reg <= char_now;
            out_last_reg <= cur_reg.last && at_final;
        end
    end

    assign escaped.valid       = out_valid_reg;
    assign escaped.out_char    = out_char_reg;
    assign escaped.last_of_run = out_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/json_string_escaper_utf8.sv @@
// ----------------------------------------------------------------------------
// json_string_escaper_utf8: streaming JSON string escaper
// Turns raw UTF-8 string bytes into the characters of a quoted JSON string.
// ----------------------------------------------------------------------------
// Usage:
//   raw carries one transaction per string byte (mode 0) or an end-of-string
//   mark (mode 1). escaped carries the ASCII characters of the quoted form;
//   last_of_run marks the final character caused by one raw transaction.
//   The first transaction of a string yields the opening quote, the end mark
//   the closing quote. Bytes of an incomplete UTF-8 sequence are held and
//   give no characters until the sequence completes or breaks.
// Timing:
//   The classifier registers the commands of a transaction when it accepts
//   it and then pushes them into the queue one per cycle while the queue has
//   room; it takes the next transaction once every command is issued. The
//   emitter sends one character per cycle while the receiver is ready. The
//   first character of a transaction passes through the classifier's slot
//   mask, the queue, the emitter's command register and the output register.
// Reset and stalls:
//   Reset drops any held sequence and starts a new string. A stalled
//   receiver backs up the output register, then the queue, then raw.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_utf8 #(
    parameter int FIFO_DEPTH = 4
) (
    input wire logic  clk,
    input wire logic  rst_n,
    jse_in_if.sink    raw,
    jse_out_if.source escaped
);

    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    jse_pkg::cmd_t push_cmd, pop_cmd;

    jse_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd)
    );

    jse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    jse_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .escaped   (escaped)
    );

endmodule

`default_nettype wire

@@ tb/json_string_escaper_utf8_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_tb: self-checking testbench of the JSON escaper
// Drives raw string bytes and end marks, predicts the quoted JSON characters
// in step with every accepted transaction and compares each character that
// leaves the block. Covers the escapes, UTF-8 sequences, broken sequences,
// random strings under changing idle patterns and a long output stall.
// ----------------------------------------------------------------------------

module json_string_escaper_utf8_tb;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic [7:0] B_BS  = 8'h08;
    localparam logic [7:0] B_TAB = 8'h09;
    localparam logic [7:0] B_LF  = 8'h0a;
    localparam logic [7:0] B_FF  = 8'h0c;
    localparam logic [7:0] B_CR  = 8'h0d;
    localparam logic [7:0] B_DEL = 8'h7f;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } esc_char_t;

    logic clk;
    logic rst_n;

    jse_in_if  raw_ch ();
    jse_out_if esc_ch ();

    json_string_escaper_utf8 i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_ch),
        .escaped (esc_ch)
    );

    // Characters still owed by the block, oldest first.
    esc_char_t   expected_chars[$];
    esc_char_t   item_chars[$];
    esc_char_t   head_char;

    // Escaper state as the block should hold it.
    logic        str_open;
    logic [7:0]  held [3];
    logic [1:0]  held_cnt;
    logic [1:0]  still_needed;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned hold_reqs;
    int unsigned hold_done;
    logic        rx_hold;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void push_char(input logic [6:0] c);
        esc_char_t e;
        e.ch   = c;
        e.last = 1'b0;
        item_chars.push_back(e);
    endfunction

    function automatic void push_escape(input logic [6:0] c);
        push_char(jse_pkg::CH_BSLASH);
        push_char(c);
    endfunction

    function automatic void push_u16(input logic [15:0] v);
        logic [3:0] d;
        push_char(jse_pkg::CH_BSLASH);
        push_char(jse_pkg::CH_U);
        for (int k = 3; k >= 0; k--)
        begin
            d = v[k*4 +: 4];
            push_char((d < 4'd10) ? jse_pkg::CH_ZERO + 7'(d) : 7'h57 + 7'(d));
        end
    endfunction

    function automatic void push_single(input logic [7:0] b);
        case (b)
            8'h22:   push_escape(jse_pkg::CH_QUOTE);
            8'h5c:   push_escape(jse_pkg::CH_BSLASH);
            8'h2f:   push_escape(jse_pkg::CH_SLASH);
            B_LF:    push_escape(7'("n"));
            B_CR:    push_escape(7'("r"));
            B_FF:    push_escape(7'("f"));
            B_BS:    push_escape(7'("b"));
            B_TAB:   push_escape(7'("t"));
            default:
            begin
                if (b < 8'h20 || b >= B_DEL)
                    push_u16({8'h00, b});
                else
                    push_char(b[6:0]);
            end
        endcase
    endfunction

    function automatic void start_byte(input logic [7:0] b);
        logic [1:0] need;
        need = 2'd0;
        if (b[7:5] == 3'b110)
            need = 2'd1;
        else if (b[7:4] == 4'b1110)
            need = 2'd2;
        else if (b[7:3] == 5'b11110)
            need = 2'd3;
        if (need != 2'd0)
        begin
            held[0]      = b;
            held_cnt     = 2'd1;
            still_needed = need;
        end
        else
        begin
            push_single(b);
        end
    endfunction

    // A held sequence that did not complete: the lead and each held
    // continuation byte come out on their own.
    function automatic void flush_held();
        push_u16({8'h00, held[0]});
        for (int i = 1; i < held_cnt; i++)
            push_single(held[i]);
        held_cnt     = 2'd0;
        still_needed = 2'd0;
    endfunction

    function automatic void complete_seq(input logic [7:0] b);
        logic [31:0] cp;
        if (held[0][7:5] == 3'b110)
            cp = {27'd0, held[0][4:0]};
        else if (held[0][7:4] == 4'b1110)
            cp = {28'd0, held[0][3:0]};
        else
            cp = {29'd0, held[0][2:0]};
        for (int i = 1; i < held_cnt; i++)
            cp = (cp << 6) | {26'd0, held[i][5:0]};
        cp = (cp << 6) | {26'd0, b[5:0]};
        if (held[0][7:3] == 5'b11110)
        begin
            // Overlong four-byte forms wrap around here, as the block does.
            cp = cp - {12'd0, jse_pkg::SUPP_OFFSET};
            push_u16(jse_pkg::SURR_HI_BASE + {6'd0, cp[19:10]});
            push_u16(jse_pkg::SURR_LO_BASE + {6'd0, cp[9:0]});
        end
        else
        begin
            push_u16(cp[15:0]);
        end
        held_cnt     = 2'd0;
        still_needed = 2'd0;
    endfunction

    function automatic void predict_escape(input logic m, input logic [7:0] b);
        item_chars = {};
        if (!str_open)
        begin
            push_char(jse_pkg::CH_QUOTE);
            str_open = 1'b1;
        end
        if (m == MODE_BYTE)
        begin
            if (held_cnt != 2'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    if (still_needed <= 2'd1)
                    begin
                        complete_seq(b);
                    end
                    else if (held_cnt < 2'd3)
                    begin
                        held[held_cnt] = b;
                        held_cnt       = held_cnt + 2'd1;
                        still_needed   = still_needed - 2'd1;
                    end
                    else
                    begin
                        complete_seq(b);
                    end
                end
                else
                begin
                    flush_held();
                    start_byte(b);
                end
            end
            else
            begin
                start_byte(b);
            end
        end
        else
        begin
            if (held_cnt != 2'd0)
                flush_held();
            push_char(jse_pkg::CH_QUOTE);
            str_open = 1'b0;
        end
        if (item_chars.size() > 0)
            item_chars[item_chars.size() - 1].last = 1'b1;
        foreach (item_chars[i])
            expected_chars.push_back(item_chars[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, receiver and checker
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("json_string_escaper_utf8_tb NOT OK");
        $finish;
    end

    // Long receiver stall, served whenever a test asks for one.
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_done)
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
                hold_done++;
            end
        end
    end

    initial
    begin
        esc_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            esc_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && esc_ch.valid && esc_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char %h last %b",
                                          esc_ch.out_char, esc_ch.last_of_run));
            end
            else
            begin
                head_char = expected_chars.pop_front();
                if (esc_ch.out_char !== head_char.ch
                    || esc_ch.last_of_run !== head_char.last)
                    report_mismatch($sformatf("expected char %h last %b, got %h last %b",
                                              head_char.ch, head_char.last,
                                              esc_ch.out_char, esc_ch.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Leaves valid high after the transaction; the next call either idles
    // it or replaces the payload in the same time step.
    task automatic send_item(input logic m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            raw_ch.valid <= 1'b0;
            @(posedge clk);
        end
        raw_ch.valid   <= 1'b1;
        raw_ch.mode    <= m;
        raw_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!raw_ch.ready);
        predict_escape(m, b);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_special();
        logic [7:0] b;
        case ($urandom_range(10))
            0:       b = 8'h22;
            1:       b = 8'h5c;
            2:       b = 8'h2f;
            3:       b = B_BS;
            4:       b = B_TAB;
            5:       b = B_LF;
            6:       b = B_FF;
            7:       b = B_CR;
            8:       b = 8'h00;
            9:       b = B_DEL;
            default: b = 8'($urandom_range(31));
        endcase
        return b;
    endfunction

    // Sends the first 'keep' bytes of a 'len'-byte UTF-8 sequence.
    task automatic send_utf8(input int unsigned len, input int unsigned keep);
        logic [7:0] lead;
        case (len)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        send_item(MODE_BYTE, lead);
        for (int k = 1; k < keep; k++)
            send_item(MODE_BYTE, {2'b10, 6'($urandom)});
    endtask

    task automatic send_unit();
        int unsigned sel;
        int unsigned len;
        sel = $urandom_range(99);
        len = $urandom_range(4, 2);
        if (sel < 35)
            send_item(MODE_BYTE, 8'($urandom_range(8'h7e, 8'h20)));
        else if (sel < 45)
            send_item(MODE_BYTE, pick_special());
        else if (sel < 80)
            send_utf8(len, len);
        else if (sel < 90)
            send_utf8(len, $urandom_range(len - 1, 1));
        else
            send_item(MODE_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic test_directed_escapes();
        // Empty string first, then every escape class and the byte limits.
        send_item(MODE_END, 8'h00);
        send_item(MODE_BYTE, 8'h22);
        send_item(MODE_BYTE, 8'h5c);
        send_item(MODE_BYTE, 8'h2f);
        send_item(MODE_BYTE, B_LF);
        send_item(MODE_BYTE, B_CR);
        send_item(MODE_BYTE, B_FF);
        send_item(MODE_BYTE, B_BS);
        send_item(MODE_BYTE, B_TAB);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, B_DEL);
        send_item(MODE_BYTE, 8'h80);
        send_item(MODE_BYTE, 8'hff);
    endtask

    task automatic test_directed_utf8();
        send_item(MODE_BYTE, 8'hc3);
        send_item(MODE_BYTE, 8'ha9);
        send_item(MODE_BYTE, 8'he2);
        send_item(MODE_BYTE, 8'h82);
        send_item(MODE_BYTE, 8'hac);
        // Overlong four-byte form: the surrogate offset wraps below zero.
        send_item(MODE_BYTE, 8'hf0);
        send_item(MODE_BYTE, 8'h80);
        send_item(MODE_BYTE, 8'h81);
        send_item(MODE_BYTE, 8'hbf);
        // Sequence broken by a plain byte, then one broken by the end mark.
        send_item(MODE_BYTE, 8'he2);
        send_item(MODE_BYTE, 8'h80);
        send_item(MODE_BYTE, 8'h41);
        send_item(MODE_BYTE, 8'hf0);
        send_item(MODE_END, 8'hff);
    endtask

    task automatic test_random_strings(input int unsigned n_items);
        int unsigned target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            repeat ($urandom_range(10)) send_unit();
            send_item(MODE_END, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        repeat (30) send_unit();
        send_item(MODE_END, 8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        raw_ch.valid   = 1'b0;
        raw_ch.mode    = MODE_BYTE;
        raw_ch.in_byte = 8'h00;
        str_open       = 1'b0;
        held_cnt       = 2'd0;
        still_needed   = 2'd0;
        send_idle_pct  = 23;
        recv_idle_pct  = 82;
        items_sent     = 0;
        mismatches     = 0;
        hold_reqs      = 0;
        hold_done      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_escapes();
        test_directed_utf8();
        test_random_strings(120);
        send_idle_pct = 82;
        recv_idle_pct = 23;
        test_random_strings(120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(120);
        test_output_stall();
        raw_ch.valid <= 1'b0;

        while (expected_chars.size() != 0 || hold_reqs != hold_done)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("json_string_escaper_utf8_tb OK");
        else
            $display("json_string_escaper_utf8_tb NOT OK");
        $finish;
    end

endmodule
